// ===== src/kptd_pkg.sv =====
package kptd_pkg;

	localparam int PERIOD_W = 16;
	localparam int PRESS_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CH_W = 2;
	localparam int IN_BYTES_W = 8;
	localparam int OUT_W = 8;

	localparam int NUM_CHANNELS_DEF = 3;
	localparam int LED_HALF_PERIOD_DEF = 500;

	localparam logic [CFG_IDX_W-1:0] REG_SEND_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1_MIN_PRESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OTHER_MIN_PRESS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESS = 3'd4;

	localparam logic [PERIOD_W-1:0] SEND_PERIOD_RST = 16'd100;
	localparam logic [PERIOD_W-1:0] REFRESH_PERIOD_RST = 16'd50;
	localparam logic [PRESS_W-1:0] KEY1_MIN_PRESS_RST = 11'd20;
	localparam logic [PRESS_W-1:0] OTHER_MIN_PRESS_RST = 11'd10;
	localparam logic [PRESS_W-1:0] MAX_PRESS_RST = 11'd2000;

	localparam logic [PRESS_W-1:0] COUNT_TOP = 11'h7FF;

	typedef struct packed {
		logic            channel_changed;
		logic [CH_W-1:0] channel_index;
		logic            key2_click;
		logic            key1_click;
		logic            led_level;
		logic            refresh_pulse;
		logic            send_pulse;
	} result_t;

endpackage

// ===== src/kptd_key.sv =====
module kptd_key
	import kptd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               level,
	input  logic [PRESS_W-1:0] min_press,
	input  logic [PRESS_W-1:0] max_press,
	output logic               click
);

	logic               prev_q;
	logic               held_q;
	logic [PRESS_W-1:0] count_q;

	logic               fall;
	logic               rise;
	logic               held_d;
	logic [PRESS_W-1:0] count_base;
	logic [PRESS_W-1:0] count_d;

	always_comb begin
		fall = prev_q & ~level;
		rise = ~prev_q & level;
		held_d = rise ? 1'b0 : (fall ? 1'b1 : held_q);
		click = rise && (count_q >= min_press) && (count_q < max_press);
		count_base = rise ? '0 : count_q;
		if (held_d && (count_base != COUNT_TOP)) begin
			count_d = count_base + PRESS_W'(1);
		end else begin
			count_d = count_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			held_q <= 1'b0;
			count_q <= '0;
		end else if (step) begin
			prev_q <= level;
			held_q <= held_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== src/key_press_and_tick_divider.sv =====
// Tick-rate key qualifier and event divider. Each input beat is one 1 ms tick carrying the
// three active-low key levels; each tick yields exactly one output beat with the send and
// refresh pulses, the LED level, the key 1 and key 2 clicks, and the channel index with its
// change flag. The block takes one beat per clock cycle while the output is not stalled. Each
// beat is captured in the input register, then the counters, key qualifiers and channel select
// update together into the output register, which presents the result. Input ready drops only
// while the output register holds an untaken beat and the input register is full. Write
// registers via the cfg port only while no tick is in flight; the block does not enforce it.
module key_press_and_tick_divider
	import kptd_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int LED_HALF_PERIOD = LED_HALF_PERIOD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// key1_level, key2_level, key3_level, then zero fill.
	input  logic [IN_BYTES_W-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// send_pulse, refresh_pulse, led_level, key1_click, key2_click,
	// channel_index (2 bits), channel_changed.
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PERIOD_W-1:0]   cfg_data
);

	localparam int LED_W = $clog2(LED_HALF_PERIOD);

	logic [PERIOD_W-1:0] send_period_q;
	logic [PERIOD_W-1:0] refresh_period_q;
	logic [PRESS_W-1:0]  key1_min_q;
	logic [PRESS_W-1:0]  other_min_q;
	logic [PRESS_W-1:0]  max_press_q;

	logic                s1_valid;
	logic [2:0]          levels_s1;
	logic                advance;

	logic [PERIOD_W-1:0] send_count_q;
	logic [PERIOD_W-1:0] refresh_count_q;
	logic [LED_W-1:0]    led_count_q;
	logic                led_q;
	logic [CH_W-1:0]     channel_q;

	logic [PERIOD_W:0]   send_next;
	logic [PERIOD_W:0]   refresh_next;
	logic [LED_W:0]      led_next;
	logic [CH_W:0]       channel_next;
	logic                send_hit;
	logic                refresh_hit;
	logic                led_hit;
	logic                click1;
	logic                click2;
	logic                click3;
	logic                led_d;
	logic [CH_W-1:0]     channel_d;
	result_t             result_d;
	result_t             result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_period_q <= SEND_PERIOD_RST;
			refresh_period_q <= REFRESH_PERIOD_RST;
			key1_min_q <= KEY1_MIN_PRESS_RST;
			other_min_q <= OTHER_MIN_PRESS_RST;
			max_press_q <= MAX_PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEND_PERIOD: begin
					send_period_q <= cfg_data;
				end
				REG_REFRESH_PERIOD: begin
					refresh_period_q <= cfg_data;
				end
				REG_KEY1_MIN_PRESS: begin
					key1_min_q <= cfg_data[PRESS_W-1:0];
				end
				REG_OTHER_MIN_PRESS: begin
					other_min_q <= cfg_data[PRESS_W-1:0];
				end
				REG_MAX_PRESS: begin
					max_press_q <= cfg_data[PRESS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance = s1_valid && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			levels_s1 <= s_tdata[2:0];
		end
	end

	kptd_key u_key1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.level     (levels_s1[0]),
		.min_press (key1_min_q),
		.max_press (max_press_q),
		.click     (click1)
	);

	kptd_key u_key2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.level     (levels_s1[1]),
		.min_press (other_min_q),
		.max_press (max_press_q),
		.click     (click2)
	);

	kptd_key u_key3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.level     (levels_s1[2]),
		.min_press (other_min_q),
		.max_press (max_press_q),
		.click     (click3)
	);

	always_comb begin
		send_next = {1'b0, send_count_q} + (PERIOD_W+1)'(1);
		refresh_next = {1'b0, refresh_count_q} + (PERIOD_W+1)'(1);
		led_next = {1'b0, led_count_q} + (LED_W+1)'(1);
		send_hit = send_next >= {1'b0, send_period_q};
		refresh_hit = refresh_next >= {1'b0, refresh_period_q};
		led_hit = led_next >= (LED_W+1)'(LED_HALF_PERIOD);
		led_d = led_q ^ led_hit;
		channel_next = {1'b0, channel_q} + (CH_W+1)'(1);
		if (!click3) begin
			channel_d = channel_q;
		end else if (channel_next >= (CH_W+1)'(NUM_CHANNELS)) begin
			channel_d = '0;
		end else begin
			channel_d = channel_next[CH_W-1:0];
		end
		result_d.send_pulse = send_hit;
		result_d.refresh_pulse = refresh_hit;
		result_d.led_level = led_d;
		result_d.key1_click = click1;
		result_d.key2_click = click2;
		result_d.channel_index = channel_d;
		result_d.channel_changed = click3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_count_q <= '0;
			refresh_count_q <= '0;
			led_count_q <= '0;
			led_q <= 1'b0;
			channel_q <= '0;
		end else if (advance) begin
			send_count_q <= send_hit ? '0 : send_next[PERIOD_W-1:0];
			refresh_count_q <= refresh_hit ? '0 : refresh_next[PERIOD_W-1:0];
			led_count_q <= led_hit ? '0 : led_next[LED_W-1:0];
			led_q <= led_d;
			channel_q <= channel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_tdata = result_q;

`ifndef ASSERT_OFF
	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CH_W+1)'(channel_q) < (CH_W+1)'(NUM_CHANNELS))
		else $error("channel select out of range");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("output register not loaded after a tick advanced");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid && m_tvalid && !m_tready))
		else $error("input stalled while the pipeline could move");

	a_click3_moves_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && click3) |=> (channel_q != $past(channel_q)))
		else $error("key 3 click did not change the channel");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
	import kptd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_OFF_AT = 100;
	localparam int HOLD_OFF_LEN = 80;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_BYTES_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]  cfg_data = '0;

	key_press_and_tick_divider dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [2:0] tick_queue[$];
	result_t    tick_results[$];

	// Register copies.
	int send_per = SEND_PERIOD_RST;
	int refresh_per = REFRESH_PERIOD_RST;
	int key1_min = KEY1_MIN_PRESS_RST;
	int other_min = OTHER_MIN_PRESS_RST;
	int press_limit = MAX_PRESS_RST;

	// Tick state.
	logic [2:0] prev_lvl = 3'b000;
	logic [2:0] pressing = 3'b000;
	int         press_len[3] = '{0, 0, 0};
	int         send_cnt = 0;
	int         refresh_cnt = 0;
	int         led_cnt = 0;
	logic       led_on = 1'b0;
	int         chan = 0;

	int ticks_in = 0;
	int results_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int key1_clicks = 0;
	int key2_clicks = 0;
	int channel_steps = 0;
	int send_pulses = 0;
	int refresh_pulses = 0;

	logic in_taken = 1'b0;
	int   in_gap = 0;
	int   out_stall = 0;
	int   hold_left = 0;
	logic held_off = 1'b0;
	logic idle_on = 1'b1;

	logic [2:0] gen_lvl = 3'b111;
	int         gen_left[3] = '{0, 0, 0};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic advance_tick(input logic [2:0] lv, output result_t r);
		int   nxt;
		int   lim;
		logic [2:0] click;
		nxt = send_cnt + 1;
		if (nxt >= send_per) begin
			send_cnt = 0;
			r.send_pulse = 1'b1;
		end else begin
			send_cnt = nxt & 16'hFFFF;
			r.send_pulse = 1'b0;
		end
		nxt = refresh_cnt + 1;
		if (nxt >= refresh_per) begin
			refresh_cnt = 0;
			r.refresh_pulse = 1'b1;
		end else begin
			refresh_cnt = nxt & 16'hFFFF;
			r.refresh_pulse = 1'b0;
		end
		nxt = led_cnt + 1;
		if (nxt >= LED_HALF_PERIOD_DEF) begin
			led_cnt = 0;
			led_on = ~led_on;
		end else begin
			led_cnt = nxt;
		end
		for (int k = 0; k < 3; k++) begin
			lim = (k == 0) ? key1_min : other_min;
			click[k] = 1'b0;
			if (prev_lvl[k] && !lv[k])
				pressing[k] = 1'b1;
			if (!prev_lvl[k] && lv[k]) begin
				pressing[k] = 1'b0;
				click[k] = (press_len[k] >= lim) && (press_len[k] < press_limit);
				press_len[k] = 0;
			end
			prev_lvl[k] = lv[k];
			if (pressing[k] && press_len[k] < COUNT_TOP)
				press_len[k]++;
		end
		if (click[2])
			chan = (chan + 1 >= NUM_CHANNELS_DEF) ? 0 : chan + 1;
		r.led_level = led_on;
		r.key1_click = click[0];
		r.key2_click = click[1];
		r.channel_index = chan[CH_W-1:0];
		r.channel_changed = click[2];
		key1_clicks += click[0];
		key2_clicks += click[1];
		channel_steps += click[2];
		send_pulses += r.send_pulse;
		refresh_pulses += r.refresh_pulse;
	endtask

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got)
			note_failure($sformatf("result %0d %s: expected %0d, got %0d",
				results_seen, field, want, got));
	endtask

	// Input side: one beat at a time from the tick queue.
	always @(negedge clk) begin
		if (s_tvalid && !in_taken) begin
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			s_tvalid <= 1'b0;
		end else if (tick_queue.size() != 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= {5'b0, tick_queue.pop_front()};
			in_gap <= pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Output side: random stalls plus one long hold-off that backs up the block.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!held_off && results_seen >= HOLD_OFF_AT) begin
			held_off <= 1'b1;
			hold_left <= HOLD_OFF_LEN;
			m_tready <= 1'b0;
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			out_stall <= pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t want;
		result_t got;
		in_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			advance_tick(s_tdata[2:0], want);
			tick_results.push_back(want);
			ticks_in++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (tick_results.size() == 0) begin
				note_failure($sformatf("result %0h arrived with nothing expected", m_tdata));
			end else begin
				want = tick_results.pop_front();
				check_field("send_pulse", want.send_pulse, got.send_pulse);
				check_field("refresh_pulse", want.refresh_pulse, got.refresh_pulse);
				check_field("led_level", want.led_level, got.led_level);
				check_field("key1_click", want.key1_click, got.key1_click);
				check_field("key2_click", want.key2_click, got.key2_click);
				check_field("channel_index", want.channel_index, got.channel_index);
				check_field("channel_changed", want.channel_changed, got.channel_changed);
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, tick_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SEND_PERIOD: send_per = val;
			REG_REFRESH_PERIOD: refresh_per = val;
			REG_KEY1_MIN_PRESS: key1_min = val[PRESS_W-1:0];
			REG_OTHER_MIN_PRESS: other_min = val[PRESS_W-1:0];
			REG_MAX_PRESS: press_limit = val[PRESS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [PERIOD_W-1:0] sp, input logic [PERIOD_W-1:0] rp,
			input logic [PERIOD_W-1:0] k1, input logic [PERIOD_W-1:0] km,
			input logic [PERIOD_W-1:0] mx);
		write_reg(REG_SEND_PERIOD, sp);
		write_reg(REG_REFRESH_PERIOD, rp);
		write_reg(REG_KEY1_MIN_PRESS, k1);
		write_reg(REG_OTHER_MIN_PRESS, km);
		write_reg(REG_MAX_PRESS, mx);
	endtask

	task automatic settle();
		while (tick_queue.size() != 0 || s_tvalid || tick_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Each key alternates released runs and held runs; held lengths straddle the thresholds.
	task automatic queue_presses(input int n, input int hold_lo, input int hold_hi);
		int         r;
		logic [2:0] lv;
		repeat (n) begin
			for (int k = 0; k < 3; k++) begin
				if (gen_left[k] == 0) begin
					gen_lvl[k] = ~gen_lvl[k];
					r = $urandom_range(0, 9);
					if (gen_lvl[k])
						gen_left[k] = $urandom_range(1, 6);
					else if (r < 7)
						gen_left[k] = $urandom_range(hold_lo, hold_hi);
					else if (r < 9)
						gen_left[k] = 1;
					else
						gen_left[k] = $urandom_range(hold_hi, 2 * hold_hi);
				end
				gen_left[k]--;
			end
			lv = gen_lvl;
			if ($urandom_range(0, 39) == 0)
				lv[$urandom_range(0, 2)] ^= 1'b1;
			tick_queue.push_back(lv);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero minimums, so the very first released tick after reset already clicks.
		write_reg(REG_KEY1_MIN_PRESS, 16'd0);
		write_reg(REG_OTHER_MIN_PRESS, 16'd0);
		tick_queue = '{3'b111, 3'b000, 3'b111, 3'b110, 3'b111, 3'b101, 3'b111,
			3'b011, 3'b111, 3'b010, 3'b101, 3'b000, 3'b000, 3'b111};
		settle();

		for (int i = REG_SPARE; i < 2 ** CFG_IDX_W; i++)
			write_reg(i[CFG_IDX_W-1:0], 16'd1);
		set_regs(16'd0, 16'd1, 16'd3, 16'd2, 16'd8);
		queue_presses(200, 1, 10);
		settle();

		set_regs(16'd1000, 16'd7, 16'd0, 16'd0, 16'hF800);
		queue_presses(150, 1, 6);
		settle();

		set_regs(16'd3, 16'hFFFF, 16'h07FF, 16'hF801, 16'hFFFF);
		queue_presses(200, 1, 8);
		settle();

		set_regs(SEND_PERIOD_RST, REFRESH_PERIOD_RST, KEY1_MIN_PRESS_RST,
			OTHER_MIN_PRESS_RST, MAX_PRESS_RST);
		queue_presses(150, 5, 30);
		settle();
		repeat (10) @(posedge clk);

		if (tick_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", tick_results.size()));
		$display("Run covered %0d ticks and %0d checked beats across five register settings.",
			ticks_in, results_seen);
		$display("Seen: %0d key 1 clicks, %0d key 2 clicks, %0d channel steps, %0d send, %0d refresh.",
			key1_clicks, key2_clicks, channel_steps, send_pulses, refresh_pulses);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
